// ===== rtl/rrs_pkg.sv =====
// ----------------------------------------------------------------------------
// rrs_pkg
// Shared constants and types for the channel signal-strength rank selector.
// ----------------------------------------------------------------------------
`default_nettype none

package rrs_pkg;

    localparam int CHANNELS_DEF = 16;

    localparam int COUNT_W = 5;
    localparam int CH_W    = 4;
    localparam int STR_W   = 8;
    localparam int RANK_W  = 4;

    localparam logic [COUNT_W-1:0] COUNT_RESET  = 5'd16;
    localparam logic [STR_W-1:0]   PAD_STRENGTH = 8'hFF;

    localparam logic FUNC_STORE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } rrs_state_t;

endpackage

`default_nettype wire

// ===== rtl/channel_rssi_rank_select.sv =====
// ----------------------------------------------------------------------------
// channel_rssi_rank_select
// Per-channel signal-strength table with stable ascending rank lookup.
// ----------------------------------------------------------------------------
// A store transaction (func 0) writes one channel's strength on acceptance and
// gives no result; busy stays low. A query transaction (func 1) returns the
// channel and strength at the given ascending rank over the first
// channel_count channels, equal strengths ordered by channel. A rank at or
// beyond the ranked count answers in the cycle after acceptance with the rank as
// channel and 255 as strength. Otherwise the search tests candidate channels
// in order, each by a full scan of the table through the single read port,
// and it answers when a candidate's count of entries ranked before it equals
// the rank. done pulses for exactly one cycle with the result and cannot be
// held off; busy is low again in that cycle, so the next transaction may
// start. The table reads as zero after reset; write cfg_wdata only while
// idle.
// ----------------------------------------------------------------------------
`default_nettype none

module channel_rssi_rank_select #(
    parameter int CHANNELS = rrs_pkg::CHANNELS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        func,
    input  wire logic [rrs_pkg::CH_W-1:0]    channel,
    input  wire logic [rrs_pkg::STR_W-1:0]   strength,
    input  wire logic [rrs_pkg::RANK_W-1:0]  rank,
    input  wire logic                        cfg_we,
    input  wire logic [rrs_pkg::COUNT_W-1:0] cfg_wdata,
    output logic                             done,
    output logic      [rrs_pkg::CH_W-1:0]    ranked_channel,
    output logic      [rrs_pkg::STR_W-1:0]   ranked_strength
);

    import rrs_pkg::*;

    localparam int AW = $clog2(CHANNELS);

    logic [COUNT_W-1:0] channel_count_reg;
    logic               mem_wr_en;
    logic [AW-1:0]      mem_wr_addr;
    logic [STR_W-1:0]   mem_wr_data;
    logic [AW-1:0]      mem_rd_addr;
    logic [STR_W-1:0]   mem_rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg <= COUNT_RESET;
        end
        else if (cfg_we)
        begin
            channel_count_reg <= cfg_wdata;
        end
    end

    rrs_seq #(
        .CHANNELS (CHANNELS)
    ) u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .func            (func),
        .channel         (channel),
        .strength        (strength),
        .rank            (rank),
        .channel_count   (channel_count_reg),
        .done            (done),
        .ranked_channel  (ranked_channel),
        .ranked_strength (ranked_strength),
        .mem_wr_en       (mem_wr_en),
        .mem_wr_addr     (mem_wr_addr),
        .mem_wr_data     (mem_wr_data),
        .mem_rd_addr     (mem_rd_addr),
        .mem_rd_data     (mem_rd_data)
    );

    rrs_mem #(
        .CHANNELS (CHANNELS)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

`default_nettype wire

// ===== rtl/rrs_mem.sv =====
// ----------------------------------------------------------------------------
// rrs_mem
// Strength table: one write port, one read port with registered data.
// Per-entry valid bits make unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module rrs_mem #(
    parameter int CHANNELS = rrs_pkg::CHANNELS_DEF,
    localparam int AW      = $clog2(CHANNELS)
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     wr_en,
    input  wire logic [AW-1:0]            wr_addr,
    input  wire logic [rrs_pkg::STR_W-1:0] wr_data,
    input  wire logic [AW-1:0]            rd_addr,
    output logic      [rrs_pkg::STR_W-1:0] rd_data
);

    import rrs_pkg::*;

    logic [STR_W-1:0]    mem [CHANNELS];
    logic [CHANNELS-1:0] valid_reg;
    logic [STR_W-1:0]    rd_data_reg;
    logic                rd_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
        rd_vld_reg  <= valid_reg[rd_addr];
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

// ===== rtl/rrs_seq.sv =====
// ----------------------------------------------------------------------------
// rrs_seq
// Transaction sequencer: stores strengths and runs the stable rank search,
// one candidate channel at a time, scanning the table through the read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rrs_seq #(
    parameter int CHANNELS = rrs_pkg::CHANNELS_DEF,
    localparam int AW      = $clog2(CHANNELS),
    localparam int CW      = $clog2(CHANNELS + 1)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        func,
    input  wire logic [rrs_pkg::CH_W-1:0]    channel,
    input  wire logic [rrs_pkg::STR_W-1:0]   strength,
    input  wire logic [rrs_pkg::RANK_W-1:0]  rank,
    input  wire logic [rrs_pkg::COUNT_W-1:0] channel_count,
    output logic                             done,
    output logic      [rrs_pkg::CH_W-1:0]    ranked_channel,
    output logic      [rrs_pkg::STR_W-1:0]   ranked_strength,
    output logic                             mem_wr_en,
    output logic      [AW-1:0]               mem_wr_addr,
    output logic      [rrs_pkg::STR_W-1:0]   mem_wr_data,
    output logic      [AW-1:0]               mem_rd_addr,
    input  wire logic [rrs_pkg::STR_W-1:0]   mem_rd_data
);

    import rrs_pkg::*;

    rrs_state_t       state_reg, state_next;
    logic [CW-1:0]    j_reg, j_next;
    logic [AW-1:0]    k_reg, k_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    pos_reg, pos_next;
    logic [STR_W-1:0] vk_reg, vk_next;
    logic [RANK_W-1:0] rank_reg, rank_next;
    logic [CH_W-1:0]  res_ch_reg, res_ch_next;
    logic [STR_W-1:0] res_str_reg, res_str_next;

    logic [CW-1:0]    n_eff;
    logic [CW-1:0]    j_prev;
    logic             hit;
    logic [CW-1:0]    pos_sum;
    logic             accept;

    assign n_eff = (32'(channel_count) > 32'(CHANNELS)) ? CW'(CHANNELS) : CW'(channel_count);
    assign accept = start && (state_reg == ST_IDLE);

    assign j_prev  = j_reg - CW'(1);
    assign hit     = (mem_rd_data < vk_reg)
                     || ((mem_rd_data == vk_reg) && (32'(j_prev) < 32'(k_reg)));
    assign pos_sum = pos_reg + CW'(hit);

    assign mem_wr_addr = AW'(channel);
    assign mem_wr_data = strength;

    always_comb
    begin
        state_next   = state_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        done_next    = 1'b0;
        pos_next     = pos_reg;
        vk_next      = vk_reg;
        rank_next    = rank_reg;
        res_ch_next  = res_ch_reg;
        res_str_next = res_str_reg;
        mem_wr_en    = 1'b0;
        mem_rd_addr  = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (func == FUNC_STORE)
                    begin
                        mem_wr_en = (32'(channel) < 32'(CHANNELS));
                    end
                    else if (32'(rank) < 32'(n_eff))
                    begin
                        state_next = ST_SCAN;
                        j_next     = '0;
                        k_next     = '0;
                        rank_next  = rank;
                    end
                    else
                    begin
                        done_next    = 1'b1;
                        res_ch_next  = rank;
                        res_str_next = PAD_STRENGTH;
                    end
                end
            end
            ST_SCAN:
            begin
                if (j_reg == '0)
                begin
                    vk_next     = mem_rd_data;
                    pos_next    = '0;
                    mem_rd_addr = j_reg[AW-1:0];
                    j_next      = j_reg + CW'(1);
                end
                else if (j_reg != n_eff)
                begin
                    pos_next    = pos_sum;
                    mem_rd_addr = j_reg[AW-1:0];
                    j_next      = j_reg + CW'(1);
                end
                else if (32'(pos_sum) == 32'(rank_reg))
                begin
                    done_next    = 1'b1;
                    res_ch_next  = CH_W'(k_reg);
                    res_str_next = vk_reg;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    k_next      = k_reg + AW'(1);
                    mem_rd_addr = k_reg + AW'(1);
                    j_next      = '0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            j_reg     <= '0;
            k_reg     <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        vk_reg      <= vk_next;
        rank_reg    <= rank_next;
        res_ch_reg  <= res_ch_next;
        res_str_reg <= res_str_next;
    end

    assign busy            = (state_reg != ST_IDLE);
    assign done            = done_reg;
    assign ranked_channel  = res_ch_reg;
    assign ranked_strength = res_str_reg;

endmodule

`default_nettype wire
